>>> rtl/core/afc_pkg.sv
// Shared types and constants for the box/frustum classifier.
// No dependencies; used by afc_row_xform and aabb_frustum_classify.
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

   localparam int MAT_WIDTH       = 32;   // one Q16.16 matrix element
   localparam int FRAC_BITS       = 16;
   localparam int FIELD_WIDTH     = 32;
   localparam int NUM_REGS        = 8;
   localparam int REG_WIDTH       = 64;
   localparam int REG_IDX_WIDTH   = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int NUM_AXES        = 3;
   localparam int NUM_ROWS        = 4;
   localparam int NUM_CORNERS     = 8;
   localparam int NUM_PLANES      = 6;
   localparam int W_ROW           = 3;

   localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
   localparam logic [1:0] CLASS_SPLIT   = 2'd1;
   localparam logic [1:0] CLASS_INSIDE  = 2'd2;

   // identity matrix
   localparam logic [REG_WIDTH-1:0] MAT_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] box_min_x;
      logic signed [FIELD_WIDTH-1:0] box_min_y;
      logic signed [FIELD_WIDTH-1:0] box_min_z;
      logic signed [FIELD_WIDTH-1:0] box_max_x;
      logic signed [FIELD_WIDTH-1:0] box_max_y;
      logic signed [FIELD_WIDTH-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic [1:0] classification;
      logic       zero_w_seen;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/afc_row_xform.sv
// One matrix row applied to all eight box corners, two register stages.
// Depends on afc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afc_row_xform
   import afc_pkg::*;
#(
   parameter int CW = 32
) (
   input  wire logic                              clock,
   input  wire logic signed [CW-1:0]              coord_lo [NUM_AXES],
   input  wire logic signed [CW-1:0]              coord_hi [NUM_AXES],
   input  wire logic signed [MAT_WIDTH-1:0]       mat_elem [NUM_AXES],
   input  wire logic signed [MAT_WIDTH-1:0]       mat_ofs,
   output logic signed [CW+MAT_WIDTH-FRAC_BITS+1:0] sum [NUM_CORNERS]
);

   localparam int PW = MAT_WIDTH + CW;   // exact product
   localparam int FW = PW - FRAC_BITS;   // floored to 16 fraction bits (Q32.16 at CW = 32)
   localparam int SW = FW + 2;           // sum of four terms

   logic signed [FW-1:0] prod_ff [NUM_AXES][2];
   logic signed [SW-1:0] sum_ff  [NUM_CORNERS];

   // stage A: six products, floored by dropping fraction bits
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [PW-1:0] prod_lo;
      logic signed [PW-1:0] prod_hi;

      assign prod_lo = mat_elem[a] * coord_lo[a];
      assign prod_hi = mat_elem[a] * coord_hi[a];

      always_ff @(posedge clock) begin
         prod_ff[a][0] <= prod_lo[PW-1:FRAC_BITS];
         prod_ff[a][1] <= prod_hi[PW-1:FRAC_BITS];
      end
   end

   // stage B: per corner, sum the min- or max-coordinate product of each axis and the offset
   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      localparam int SX = k % 2;
      localparam int SY = (k / 2) % 2;
      localparam int SZ = k / 4;

      always_ff @(posedge clock) begin
         sum_ff[k] <= SW'(prod_ff[0][SX]) + SW'(prod_ff[1][SY])
                    + SW'(prod_ff[2][SZ]) + SW'(mat_ofs);
      end

      assign sum[k] = sum_ff[k];
   end

endmodule

`default_nettype wire

>>> rtl/core/aabb_frustum_classify.sv
// Box versus view frustum classifier in clip space, Q16.16 fixed point.
// Depends on afc_pkg and afc_row_xform.
//
// A box may be started in every clock cycle: busy never rises. The result
// appears on rsp_data with rsp_strobe high for one cycle, once the box has
// passed the coordinate, product, sum, plane-test and result registers.
// Throughput is one box per cycle, carried by 24 parallel multipliers (four
// matrix rows times three axes times min/max corner value); the eight corners
// are summed from those shared products. Results cannot be held off, so the
// pipeline never stalls. The matrix is written through the csr_ port, which
// is always ready; write it only while no box is in flight. Indexes beyond
// the last register are ignored.
`timescale 1ns / 1ps
`default_nettype none

module aabb_frustum_classify
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire req_type                    req_data,
   output logic                            rsp_strobe,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [REG_WIDTH-1:0]       csr_wdata
);

   localparam int CW = (COORD_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : COORD_WIDTH;
   localparam int SW = CW + MAT_WIDTH - FRAC_BITS + 2;
   localparam int CMPW = SW + 1;

   logic [REG_WIDTH-1:0] mat_ff [NUM_REGS];

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [CW-1:0] lo_ff [NUM_AXES];
   logic signed [CW-1:0] hi_ff [NUM_AXES];
   logic signed [SW-1:0] sums [NUM_ROWS][NUM_CORNERS];

   logic [NUM_CORNERS-1:0] inside_in [NUM_PLANES];
   logic [NUM_CORNERS-1:0] inside_ff [NUM_PLANES];
   logic [NUM_CORNERS-1:0] zero_w_in;
   logic [NUM_CORNERS-1:0] zero_w_ff;
   rsp_type                rsp_in;
   rsp_type                rsp_ff;
   logic                   accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_valid && csr_ready &&
                   csr_index < CSR_INDEX_WIDTH'(NUM_REGS)) begin
         mat_ff[csr_index[REG_IDX_WIDTH-1:0]] <= csr_wdata;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 1: capture coordinates, keeping the low CW bits as signed
   always_ff @(posedge clock) begin
      lo_ff[0] <= req_data.box_min_x[CW-1:0];
      lo_ff[1] <= req_data.box_min_y[CW-1:0];
      lo_ff[2] <= req_data.box_min_z[CW-1:0];
      hi_ff[0] <= req_data.box_max_x[CW-1:0];
      hi_ff[1] <= req_data.box_max_y[CW-1:0];
      hi_ff[2] <= req_data.box_max_z[CW-1:0];
   end

   // stages 2 and 3: transform, one unit per matrix row
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      logic signed [MAT_WIDTH-1:0] elem [NUM_AXES];
      logic signed [MAT_WIDTH-1:0] ofs;

      assign elem[0] = $signed(mat_ff[2*r][MAT_WIDTH-1:0]);
      assign elem[1] = $signed(mat_ff[2*r][REG_WIDTH-1:MAT_WIDTH]);
      assign elem[2] = $signed(mat_ff[2*r+1][MAT_WIDTH-1:0]);
      assign ofs     = $signed(mat_ff[2*r+1][REG_WIDTH-1:MAT_WIDTH]);

      afc_row_xform #(
         .CW (CW)
      ) u_row (
         .clock    (clock),
         .coord_lo (lo_ff),
         .coord_hi (hi_ff),
         .mat_elem (elem),
         .mat_ofs  (ofs),
         .sum      (sums[r])
      );
   end

   // stage 4: sign-aware plane tests per corner, no divide by w
   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_test
      logic signed [CMPW-1:0] w;
      logic signed [CMPW-1:0] neg_w;

      assign w     = CMPW'(sums[W_ROW][k]);
      assign neg_w = -w;
      assign zero_w_in[k] = (w == '0);

      for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
         logic signed [CMPW-1:0] c;

         assign c = CMPW'(sums[a][k]);

         always_comb begin
            if (w > 0) begin
               inside_in[a][k]            = (c >= neg_w);
               inside_in[a + NUM_AXES][k] = (c <= w);
            end else if (w < 0) begin
               inside_in[a][k]            = (c <= neg_w);
               inside_in[a + NUM_AXES][k] = (c >= w);
            end else begin
               // w of zero: the coordinate sits at its signed infinity
               inside_in[a][k]            = (c >= 0);
               inside_in[a + NUM_AXES][k] = (c <= 0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      zero_w_ff <= zero_w_in;
   end

   // stage 5: fold the per-plane results
   always_comb begin
      logic any_out;
      logic any_split;

      any_out   = 1'b0;
      any_split = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (inside_ff[p] == '0) any_out = 1'b1;
         if (inside_ff[p] != '1) any_split = 1'b1;
      end
      if (any_out) begin
         rsp_in.classification = CLASS_OUTSIDE;
      end else if (any_split) begin
         rsp_in.classification = CLASS_SPLIT;
      end else begin
         rsp_in.classification = CLASS_INSIDE;
      end
      rsp_in.zero_w_seen = |zero_w_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = v5_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
